/* src/ilst_pkg.sv */
package ilst_pkg;

	// list geometry
	localparam int DEPTH      = 16;
	localparam int ITEM_WIDTH = 32;

	// stored word width: the item port carries at most 32 bits
	localparam int WORD_W = (ITEM_WIDTH < 32) ? ITEM_WIDTH : 32;
	localparam int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	// field widths of the ports
	localparam int CMD_W   = 3;
	localparam int INDEX_W = 8;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 9;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PUT    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic               en;     // accepted and succeeding
		logic [CMD_W-1:0]   cmd;
		logic [COUNT_W-1:0] index;  // zero-extended list position
		logic [COUNT_W-1:0] count;  // fill level before the command
	} ilst_bcast_t;

endpackage

/* src/ilst_cell.sv */
module ilst_cell
	import ilst_pkg::*;
(
	input  logic              clk,
	input  logic [POS_W-1:0]  pos,
	input  ilst_bcast_t       bc,
	input  logic [WORD_W-1:0] item,
	input  logic [WORD_W-1:0] left,
	input  logic [WORD_W-1:0] right,
	output logic [WORD_W-1:0] word_q
);

	logic [COUNT_W-1:0] pos_x;
	logic               at_idx;
	logic               above_idx;
	logic               below_cnt;
	logic               at_cnt;
	logic               below_last;
	logic               ld_item;
	logic               ld_left;
	logic               ld_right;

	assign pos_x      = COUNT_W'(pos);
	assign at_idx     = (pos_x == bc.index);
	assign above_idx  = (pos_x > bc.index);
	assign below_cnt  = (pos_x < bc.count);
	assign at_cnt     = (pos_x == bc.count);
	assign below_last = ((pos_x + COUNT_W'(1)) < bc.count);

	always_comb begin
		ld_item  = 1'b0;
		ld_left  = 1'b0;
		ld_right = 1'b0;
		if (bc.en) begin
			unique case (bc.cmd)
				CMD_APPEND: ld_item = at_cnt;
				CMD_PUT:    ld_item = at_idx;
				CMD_INSERT: begin
					ld_item = at_idx;
					ld_left = above_idx && (below_cnt || at_cnt);
				end
				CMD_REMOVE: ld_right = (at_idx || above_idx) && below_last;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ld_item) begin
			word_q <= item;
		end else if (ld_left) begin
			word_q <= left;
		end else if (ld_right) begin
			word_q <= right;
		end
	end

endmodule

/* src/indexed_insert_remove_list.sv */
// Fixed-capacity ordered list of DEPTH words held in a row of cells, one
// entry per cell. Each request transfer carries a command (append, get,
// put, insert at, remove at, clear), a list index and an item word; each
// produces exactly one response transfer with a success flag, the word read
// by get or removed by remove (zero otherwise or on failure) and the entry
// count after the command. Insert and remove shift every later entry by one
// place at once, each cell loading from its neighbour, so a new request is
// taken each cycle while the response register is free or being drained.
// The response is registered and appears in the cycle after its request
// is taken. Entries are not cleared by reset or by clear; only the fill
// count is, and cells at or beyond the count are never read.
module indexed_insert_remove_list
	import ilst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [INDEX_W-1:0] index,
	input  logic [DATA_W-1:0]  item,
	// response channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               ok,
	output logic [DATA_W-1:0]  data,
	output logic [COUNT_W-1:0] count
);

	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  fill_nxt;
	logic               rsp_valid_q;
	logic               ok_q;
	logic [DATA_W-1:0]  data_q;
	logic [COUNT_W-1:0] count_q;

	logic               req_xfer;
	logic [COUNT_W-1:0] idx_x;
	logic [COUNT_W-1:0] fill_x;
	logic               full;
	logic               in_range;
	logic               cmd_ok;
	logic [WORD_W-1:0]  rd_word;
	logic [DATA_W-1:0]  rd_data;
	logic [WORD_W-1:0]  item_w;
	ilst_bcast_t        bc;

	logic [WORD_W-1:0]  cell_word [DEPTH];

	// a new request is held off only while an old response waits
	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_xfer  = req_valid && !req_stall;

	assign idx_x    = COUNT_W'(index);
	assign fill_x   = COUNT_W'(fill_q);
	assign full     = (fill_x == COUNT_W'(DEPTH));
	assign in_range = (idx_x < fill_x);
	assign item_w   = item[WORD_W-1:0];

	always_comb begin
		cmd_ok   = 1'b0;
		fill_nxt = fill_q;
		unique case (cmd)
			CMD_APPEND: begin
				cmd_ok   = !full;
				fill_nxt = full ? fill_q : fill_q + FILL_W'(1);
			end
			CMD_GET,
			CMD_PUT:    cmd_ok = in_range;
			CMD_INSERT: begin
				cmd_ok   = in_range && !full;
				fill_nxt = cmd_ok ? fill_q + FILL_W'(1) : fill_q;
			end
			CMD_REMOVE: begin
				cmd_ok   = in_range;
				fill_nxt = in_range ? fill_q - FILL_W'(1) : fill_q;
			end
			CMD_CLEAR: begin
				cmd_ok   = 1'b1;
				fill_nxt = '0;
			end
			default: ;
		endcase
	end

	// one read port at the index; only used when the index is in range
	assign rd_word = cell_word[index[POS_W-1:0]];
	assign rd_data = (cmd_ok && (cmd == CMD_GET || cmd == CMD_REMOVE))
		? DATA_W'(rd_word) : '0;

	assign bc.en    = req_xfer && cmd_ok;
	assign bc.cmd   = cmd;
	assign bc.index = idx_x;
	assign bc.count = fill_x;

	// row of cells; each neighbour feeds the shift for insert and remove
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = item_w;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = item_w;
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end
		ilst_cell u_cell (
			.clk    (clk),
			.pos    (POS_W'(i)),
			.bc     (bc),
			.item   (item_w),
			.left   (left_w),
			.right  (right_w),
			.word_q (cell_word[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_xfer) begin
				fill_q      <= fill_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, loaded with each request transfer
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			ok_q    <= cmd_ok;
			data_q  <= rd_data;
			count_q <= COUNT_W'(fill_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign ok        = ok_q;
	assign data      = data_q;
	assign count     = count_q;

	// fill level never passes the capacity
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_x <= COUNT_W'(DEPTH))
		else $error("fill count beyond capacity");

	// a pending response always reports the live fill level
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (count_q == fill_x))
		else $error("response count differs from fill level");

	// a failed command returns no data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !ok_q) |-> (data_q == '0))
		else $error("failed command returned data");

	// clear empties the list
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && cmd == CMD_CLEAR) |=> (fill_q == '0 && ok_q))
		else $error("clear did not empty the list");

endmodule

/* test/indexed_insert_remove_list_tb.sv */
module indexed_insert_remove_list_tb
	import ilst_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 6;
	localparam int IDLE_MAX     = 9;
	// long receiver hold-off so the response register fills and backs up the request side
	localparam int HOLD_CYCLES  = 300;
	// cycles with no transfer on either channel before the run is declared hung
	localparam int STUCK_LIMIT  = 2000;
	// margin after the last response, enough for any stray extra response to surface
	localparam int DRAIN_CYCLES = 12;

	// command codes the block does not define: must fail and change nothing
	localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

	// one response as the block should produce it
	typedef struct packed {
		logic               ok;
		logic [DATA_W-1:0]  data;
		logic [COUNT_W-1:0] count;
	} list_rsp_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [CMD_W-1:0]   cmd       = '0;
	logic [INDEX_W-1:0] index     = '0;
	logic [DATA_W-1:0]  item      = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic               ok;
	logic [DATA_W-1:0]  data;
	logic [COUNT_W-1:0] count;

	// shadow copy of the list contents and fill level
	logic [WORD_W-1:0] shadow_list [DEPTH];
	int unsigned       shadow_fill = 0;

	// responses predicted for accepted requests, oldest first
	list_rsp_t outcome_q [$];

	int unsigned mismatches      = 0;
	int unsigned stuck_cycles    = 0;
	bit          req_idle_en     = 1'b1;
	bit          rsp_idle_en     = 1'b1;
	int unsigned rsp_hold_cycles = 0;

	indexed_insert_remove_list dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.index     (index),
		.item      (item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ok        (ok),
		.data      (data),
		.count     (count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Apply one command to the shadow list and return the response it should give.
	// Only entries below the fill level are ever read, so stale cells never leak out.
	function automatic list_rsp_t list_apply(input logic [CMD_W-1:0] c,
			input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] w);
		list_rsp_t   r;
		int unsigned pos;
		int unsigned k;
		r   = '0;
		pos = idx;
		case (c)
			CMD_APPEND: begin
				if (shadow_fill < DEPTH) begin
					shadow_list[shadow_fill] = w[WORD_W-1:0];
					shadow_fill++;
					r.ok = 1'b1;
				end
			end
			CMD_GET: begin
				if (pos < shadow_fill) begin
					r.data = DATA_W'(shadow_list[pos]);
					r.ok   = 1'b1;
				end
			end
			CMD_PUT: begin
				if (pos < shadow_fill) begin
					shadow_list[pos] = w[WORD_W-1:0];
					r.ok = 1'b1;
				end
			end
			CMD_INSERT: begin
				// only inside the list, never at its end, and never when full
				if (pos < shadow_fill && shadow_fill < DEPTH) begin
					for (k = shadow_fill; k > pos; k--)
						shadow_list[k] = shadow_list[k-1];
					shadow_list[pos] = w[WORD_W-1:0];
					shadow_fill++;
					r.ok = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (pos < shadow_fill) begin
					r.data = DATA_W'(shadow_list[pos]);
					for (k = pos + 1; k < shadow_fill; k++)
						shadow_list[k-1] = shadow_list[k];
					shadow_fill--;
					r.ok = 1'b1;
				end
			end
			CMD_CLEAR: begin
				shadow_fill = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.count = COUNT_W'(shadow_fill);
		return r;
	endfunction

	// Monitor: both channels sampled at the rising edge, requests before responses,
	// so prediction never races the check.
	always @(posedge clk) begin : monitor
		list_rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall)
				outcome_q.push_back(list_apply(cmd, index, item));
			if (rsp_valid && !rsp_stall) begin
				if (outcome_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected response: expected none, got ok=%0b data=%h count=%0d",
						$time, ok, data, count);
				end else begin
					want = outcome_q.pop_front();
					if (ok !== want.ok) begin
						mismatches++;
						$display("%0t: ok mismatch: expected %0b, got %0b",
							$time, want.ok, ok);
					end
					if (data !== want.data) begin
						mismatches++;
						$display("%0t: data mismatch: expected %h, got %h",
							$time, want.data, data);
					end
					if (count !== want.count) begin
						mismatches++;
						$display("%0t: count mismatch: expected %0d, got %0d",
							$time, want.count, count);
					end
				end
			end
		end
	end

	// Watchdog: any transfer on either side resets the count.
	always @(posedge clk) begin
		if (arst_n && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Response side: random stall before each transfer, or a one-off long hold-off
	// when a test asks for it.
	initial begin : rsp_drain
		int unsigned gap;
		forever begin
			if (rsp_hold_cycles != 0) begin
				gap = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else begin
				gap = rsp_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
			end
			if (gap != 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!(rsp_valid && !rsp_stall)) @(posedge clk);
		end
	end

	// Offer one request and hold it until the block takes it. Valid is left high
	// on return; the next call lowers it only if it idles first.
	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [INDEX_W-1:0] idx,
			input logic [DATA_W-1:0] w);
		int unsigned gap;
		gap = req_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		cmd       <= c;
		index     <= idx;
		item      <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// Random traffic in alternating growth and shrink phases, so the list swings
	// between empty and full. Indices mostly land near the live range; some span
	// the whole field.
	task automatic send_random_batch(input int unsigned n_items);
		bit                 growing;
		int unsigned        phase_left;
		int unsigned        r;
		logic [CMD_W-1:0]   c;
		logic [INDEX_W-1:0] idx;
		growing    = 1'b1;
		phase_left = $urandom_range(20, 60);
		repeat (n_items) begin
			if (phase_left == 0) begin
				growing    = !growing;
				phase_left = $urandom_range(20, 60);
			end
			phase_left--;
			r = $urandom_range(0, 99);
			if (r < 1)
				c = CMD_CLEAR;
			else if (r < 3)
				c = r[0] ? CMD_UNUSED_6 : CMD_UNUSED_7;
			else if (r < 18)
				c = CMD_GET;
			else if (r < 33)
				c = CMD_PUT;
			else if (growing)
				c = (r < 73) ? CMD_APPEND : (r < 90) ? CMD_INSERT : CMD_REMOVE;
			else
				c = (r < 45) ? CMD_APPEND : (r < 53) ? CMD_INSERT : CMD_REMOVE;
			if ($urandom_range(0, 99) < 85)
				idx = INDEX_W'($urandom_range(0, DEPTH));
			else
				idx = INDEX_W'($urandom_range(0, 255));
			send_cmd(c, idx, $urandom());
		end
	endtask

	// Get, put, insert and remove on an empty list: all fail; unused codes too.
	task automatic test_empty_list();
		send_cmd(CMD_GET, '0, 32'hFFFF_FFFF);
		send_cmd(CMD_PUT, 8'hFF, 32'hFFFF_FFFF);
		send_cmd(CMD_INSERT, '0, 32'h1234_5678); // insert at the end is refused, even on empty
		send_cmd(CMD_REMOVE, '0, '0);
		send_cmd(CMD_UNUSED_6, '0, 32'hAAAA_AAAA);
		send_cmd(CMD_UNUSED_7, 8'hFF, 32'h5555_5555);
	endtask

	// Fill to capacity with extreme words, then the full-list and boundary cases.
	task automatic test_fill_and_overflow();
		int unsigned      k;
		logic [DATA_W-1:0] w;
		for (k = 0; k < DEPTH; k++) begin
			if (k == 0)
				w = '0;
			else if (k == 1)
				w = '1;
			else
				w = (k[0] ? 32'hAAAA_AAAA : 32'h5555_5555) ^ DATA_W'(k);
			send_cmd(CMD_APPEND, INDEX_W'(k), w);
		end
		send_cmd(CMD_APPEND, '0, 32'hDEAD_BEEF);            // full
		send_cmd(CMD_INSERT, '0, 32'hDEAD_BEEF);            // full
		send_cmd(CMD_GET, INDEX_W'(DEPTH - 1), '0);         // last entry
		send_cmd(CMD_GET, INDEX_W'(DEPTH), '0);             // one past the end
		send_cmd(CMD_REMOVE, '0, '0);                       // head, everything shifts down
		send_cmd(CMD_INSERT, INDEX_W'(DEPTH - 2), '1);      // back to full
		send_cmd(CMD_REMOVE, INDEX_W'(DEPTH - 1), '0);      // tail
		send_cmd(CMD_CLEAR, 8'hFF, '1);
	endtask

	// Random traffic with both sides idling at random.
	task automatic test_random_traffic();
		req_idle_en = 1'b1;
		rsp_idle_en = 1'b1;
		send_random_batch(850);
	endtask

	// Full rate: no gaps on either side.
	task automatic test_back_to_back();
		req_idle_en = 1'b0;
		rsp_idle_en = 1'b0;
		send_random_batch(400);
	endtask

	// Receiver holds off for a long stretch while requests keep coming, so the
	// block must stall its request side; then random stalls resume.
	task automatic test_backpressure();
		req_idle_en     = 1'b0;
		rsp_idle_en     = 1'b1;
		rsp_hold_cycles = HOLD_CYCLES;
		send_random_batch(420);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_fill_and_overflow();
		test_random_traffic();
		test_back_to_back();
		test_backpressure();

		req_valid <= 1'b0;
		@(posedge clk);
		// the watchdog bounds this wait
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outcome_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
